// File: rtl/core/aabb_overlap_scan_assert.svh
// -----------------------------------------------------------------------------
// aabb_overlap_scan_assert.svh
// Assertion macros used by the checker of the box overlap scanner.
// -----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_SCAN_ASSERT_SVH
`define AABB_OVERLAP_SCAN_ASSERT_SVH

// Same-cycle implication, sampled on clk and muted during reset.
`define AOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted during reset.
`define AOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/aos_pkg.sv
// -----------------------------------------------------------------------------
// aos_pkg
// Types and codes shared by the box overlap scanner.
// -----------------------------------------------------------------------------
package aos_pkg;

  // Item kinds carried by the mode field.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Query test kinds; unlisted codes run the full box test.
  localparam logic [2:0] KIND_FULL   = 3'd0;
  localparam logic [2:0] KIND_LEFT   = 3'd1;
  localparam logic [2:0] KIND_RIGHT  = 3'd2;
  localparam logic [2:0] KIND_TOP    = 3'd3;
  localparam logic [2:0] KIND_BOTTOM = 3'd4;

  // Width of the widened coordinate arithmetic.
  localparam int unsigned CW = 18;

  // One stored box, as held in the table memory.
  typedef struct packed {
    logic [15:0] tag;
    logic [14:0] height;
    logic [14:0] width;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  // Query span, margin and tag, fixed for the duration of one scan.
  typedef struct packed {
    logic signed [CW-1:0] xlo;
    logic signed [CW-1:0] xhi;
    logic signed [CW-1:0] ylo;
    logic signed [CW-1:0] yhi;
    logic signed [12:0]   margin;
    logic [15:0]          tag;
  } query_t;

endpackage

// File: rtl/core/aabb_overlap_scan.sv
// -----------------------------------------------------------------------------
// aabb_overlap_scan
// Table of boxes scanned for the first inclusive overlap with a query box.
// -----------------------------------------------------------------------------
// Usage: the input channel carries one word per item. A write word (mode 0)
// stores a box in a table slot in the cycle it is accepted and gives no
// result; slots at or above MAX_ENTRIES are ignored. A query word (mode 1)
// scans slots 0 to list_length-1 (at most MAX_ENTRIES) and gives exactly one
// result word: a hit flag and the slot of the first hit, zero when none.
// Flow: a write leaves the input open for the next word. A query with a scan
// of n slots holds in_ready low until its scan ends and its result leaves
// ST_DONE, since the table memory is read one slot per cycle through its
// single read port with registered read data. A hit ends the scan early.
// The result register sits between the channels, so the next word is
// accepted while a result still waits; a second result waits in the block,
// with in_ready low, until out_ready takes the first one.
// Reset clears the control state and out_valid; table contents are
// undefined until written, so queries must only scan written slots.
// -----------------------------------------------------------------------------
module aabb_overlap_scan
  import aos_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [5:0]         in_entry_index,
  input  logic [6:0]         in_list_length,
  input  logic signed [15:0] in_box_x,
  input  logic signed [15:0] in_box_y,
  input  logic [14:0]        in_box_width,
  input  logic [14:0]        in_box_height,
  input  logic [15:0]        in_box_tag,
  input  logic signed [12:0] in_margin,
  input  logic [2:0]         in_test_kind,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [5:0]         out_hit_index
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state_r;
  query_t           query_r;
  query_t           query_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] issue_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             res_hit_r;
  logic [5:0]       res_idx_r;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [5:0]       out_hit_index_r;

  logic             accept;
  logic             wr_en;
  logic             issue_en;
  logic [IDX_W-1:0] issue_addr;
  logic             res_load;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             entry_hit;

  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;
  logic signed [CW-1:0] qw;
  logic signed [CW-1:0] qh;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Table write for a write word aimed at a slot that exists.
  assign wr_en = accept && (in_mode == MODE_WRITE) &&
                 (32'(in_entry_index) < MAX_ENTRIES);
  assign wr_entry = '{tag: in_box_tag, height: in_box_height, width: in_box_width,
                      y: in_box_y, x: in_box_x};

  // Query span from the query box and test kind.
  assign qx = {{(CW-16){in_box_x[15]}}, in_box_x};
  assign qy = {{(CW-16){in_box_y[15]}}, in_box_y};
  assign qw = {{(CW-15){1'b0}}, in_box_width};
  assign qh = {{(CW-15){1'b0}}, in_box_height};

  always_comb begin
    query_nxt.xlo    = qx;
    query_nxt.xhi    = qx + qw;
    query_nxt.ylo    = qy;
    query_nxt.yhi    = qy + qh;
    query_nxt.margin = in_margin;
    query_nxt.tag    = in_box_tag;
    case (in_test_kind)
      KIND_LEFT:   query_nxt.xhi = qx + CW'(1);
      KIND_RIGHT:  query_nxt.xlo = qx + qw - CW'(1);
      KIND_TOP:    query_nxt.yhi = qy + CW'(1);
      KIND_BOTTOM: query_nxt.ylo = qy + qh - CW'(1);
      default: begin
      end
    endcase
  end

  // Number of slots to scan, clipped to the table depth.
  always_comb begin
    if (32'(in_list_length) > MAX_ENTRIES) begin
      count_nxt = CNT_W'(MAX_ENTRIES);
    end else begin
      count_nxt = CNT_W'(in_list_length);
    end
  end

  // Read one slot per cycle while the scan has slots left.
  assign issue_en   = (state_r == ST_SCAN) && (issue_r < count_r);
  assign issue_addr = issue_r[IDX_W-1:0];

  // A finished scan moves into the result register once it is free.
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  aos_table #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_entry_index)),
    .wr_data (wr_entry),
    .rd_en   (issue_en),
    .rd_addr (issue_addr),
    .rd_data (rd_entry)
  );

  aos_test u_test (
    .entry (rd_entry),
    .query (query_r),
    .hit   (entry_hit)
  );

  // Scan sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r     <= 1'b1;
        out_hit_r       <= res_hit_r;
        out_hit_index_r <= res_idx_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          rd_vld_r <= 1'b0;
          if (accept && (in_mode == MODE_QUERY)) begin
            query_r <= query_nxt;
            count_r <= count_nxt;
            issue_r <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld_r <= issue_en && !(rd_vld_r && entry_hit);
          rd_idx_r <= issue_addr;
          if (issue_en) begin
            issue_r <= issue_r + CNT_W'(1);
          end
          if (rd_vld_r && entry_hit) begin
            res_hit_r <= 1'b1;
            res_idx_r <= 6'(rd_idx_r);
            state_r   <= ST_DONE;
          end else if (!issue_en && !rd_vld_r) begin
            res_hit_r <= 1'b0;
            res_idx_r <= '0;
            state_r   <= ST_DONE;
          end
        end
        ST_DONE: begin
          rd_vld_r <= 1'b0;
          if (res_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_index = out_hit_index_r;

endmodule

// File: rtl/core/aos_table.sv
// -----------------------------------------------------------------------------
// aos_table
// Box table memory: one write port and one read port with registered data.
// -----------------------------------------------------------------------------
module aos_table
  import aos_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/aos_test.sv
// -----------------------------------------------------------------------------
// aos_test
// Overlap test of one stored box, grown by the margin, against the query span.
// -----------------------------------------------------------------------------
module aos_test
  import aos_pkg::*;
(
  input  entry_t entry,
  input  query_t query,
  output logic   hit
);

  logic signed [CW-1:0] ex;
  logic signed [CW-1:0] ey;
  logic signed [CW-1:0] ew;
  logic signed [CW-1:0] eh;
  logic signed [CW-1:0] m;
  logic signed [CW-1:0] right_edge;
  logic signed [CW-1:0] left_edge;
  logic signed [CW-1:0] bottom_edge;
  logic signed [CW-1:0] top_edge;

  // Widen the stored fields so no sum wraps.
  assign ex = {{(CW-16){entry.x[15]}}, entry.x};
  assign ey = {{(CW-16){entry.y[15]}}, entry.y};
  assign ew = {{(CW-15){1'b0}}, entry.width};
  assign eh = {{(CW-15){1'b0}}, entry.height};
  assign m  = {{(CW-13){query.margin[12]}}, query.margin};

  // Edges of the grown box.
  assign right_edge  = ex + ew + m;
  assign left_edge   = ex - m;
  assign bottom_edge = ey + eh + m;
  assign top_edge    = ey - m;

  // Inclusive overlap on both axes; entries sharing the query tag never hit.
  assign hit = (entry.tag != query.tag) &&
               (right_edge >= query.xlo) && (left_edge <= query.xhi) &&
               (bottom_edge >= query.ylo) && (top_edge <= query.yhi);

endmodule

// File: rtl/core/aos_checker.sv
// -----------------------------------------------------------------------------
// aos_checker
// Port-level checks of the box overlap scanner, bound to its top level.
// -----------------------------------------------------------------------------
`include "aabb_overlap_scan_assert.svh"

module aos_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic [5:0]         out_hit_index
);

  // A stalled result word holds its value.
  `AOS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_hit_index), "result word changed while stalled")

  // A miss always reports slot zero.
  `AOS_ASSERT_NOW(a_miss_index, out_valid && !out_hit, out_hit_index == 6'd0, "miss with nonzero index")

  // A write word never raises a result on its own.
  `AOS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && !in_mode && !out_valid, !out_valid, "write word produced a result")

  // A query keeps the input closed while it scans.
  `AOS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_mode, !in_ready, "input open right after a query")

endmodule

bind aabb_overlap_scan aos_checker u_aos_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hit       (out_hit),
  .out_hit_index (out_hit_index)
);

// File: test/aabb_overlap_scan_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aabb_overlap_scan_test
// Self-checking regression for the box table overlap scanner.
// -----------------------------------------------------------------------------
// The table is first filled with parked boxes so that every slot holds a known
// box and any list length may be scanned. A short table of directed words then
// covers the empty and over-long lists, tag skipping, each strip test, the
// spare test kinds, the margin extremes and the coordinate extremes. Random
// words follow, clustered around moving scene centers so that hits and misses
// both occur. Each result is checked against its typed value or a behavioral
// scan of a shadow table; channels idle and stall at random except when steady.
// -----------------------------------------------------------------------------
module aabb_overlap_scan_test;
  import aos_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_WORDS = 1760;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;
  localparam int IDLE_PERCENT = 13;

  // Spare test kind codes; the block treats them as the full box test.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Tag and corner of the boxes parked in every slot before the directed words.
  localparam int PARK_TAG = 16'hFFFF;
  localparam int PARK_COORD = -32768;

  typedef struct {
    logic               mode;
    logic [5:0]         entry_index;
    logic [6:0]         list_length;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [15:0]        box_tag;
    logic signed [12:0] margin;
    logic [2:0]         test_kind;
  } box_word_t;

  typedef struct {
    bit         hit;
    logic [5:0] hit_index;
  } scan_result_t;

  typedef struct {
    box_word_t    word;
    bit           typed;
    scan_result_t result;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = 1'b0;
  logic [5:0]         in_entry_index = '0;
  logic [6:0]         in_list_length = '0;
  logic signed [15:0] in_box_x = '0;
  logic signed [15:0] in_box_y = '0;
  logic [14:0]        in_box_width = '0;
  logic [14:0]        in_box_height = '0;
  logic [15:0]        in_box_tag = '0;
  logic signed [12:0] in_margin = '0;
  logic [2:0]         in_test_kind = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hit;
  logic [5:0]         out_hit_index;

  // Shadow copy of the box table.
  logic signed [15:0] tbl_x [SLOTS];
  logic signed [15:0] tbl_y [SLOTS];
  logic [14:0]        tbl_w [SLOTS];
  logic [14:0]        tbl_h [SLOTS];
  logic [15:0]        tbl_tag [SLOTS];

  scan_result_t scan_expect_q[$];
  script_row_t  script[$];
  bit           steady = 1'b0;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           scene_cx = 0;
  int           scene_cy = 0;

  aabb_overlap_scan u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_list_length (in_list_length),
    .in_box_x       (in_box_x),
    .in_box_y       (in_box_y),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_box_tag     (in_box_tag),
    .in_margin      (in_margin),
    .in_test_kind   (in_test_kind),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_hit_index  (out_hit_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic box_word_t make_word(logic mode, int slot, int len, int x, int y,
                                          int w, int h, int tag, int margin, int kind);
    box_word_t word;
    word.mode = mode;
    word.entry_index = slot[5:0];
    word.list_length = len[6:0];
    word.box_x = x[15:0];
    word.box_y = y[15:0];
    word.box_width = w[14:0];
    word.box_height = h[14:0];
    word.box_tag = tag[15:0];
    word.margin = margin[12:0];
    word.test_kind = kind[2:0];
    return word;
  endfunction

  function automatic void add_row(box_word_t word, bit typed, bit hit, int idx);
    script_row_t row;
    row.word = word;
    row.typed = typed;
    row.result.hit = hit;
    row.result.hit_index = idx[5:0];
    script.push_back(row);
  endfunction

  function automatic void add_write(int slot, int x, int y, int w, int h, int tag);
    add_row(make_word(MODE_WRITE, slot, 0, x, y, w, h, tag, 0, KIND_FULL), 1'b0, 1'b0, 0);
  endfunction

  function automatic void add_query(int len, int x, int y, int w, int h, int tag,
                                    int margin, int kind, bit typed, bit hit, int idx);
    add_row(make_word(MODE_QUERY, 0, len, x, y, w, h, tag, margin, kind), typed, hit, idx);
  endfunction

  function automatic void store_box(box_word_t word);
    tbl_x[word.entry_index] = word.box_x;
    tbl_y[word.entry_index] = word.box_y;
    tbl_w[word.entry_index] = word.box_width;
    tbl_h[word.entry_index] = word.box_height;
    tbl_tag[word.entry_index] = word.box_tag;
  endfunction

  // First slot, in scan order, with another tag whose grown box touches the query span.
  function automatic scan_result_t scan_table(box_word_t q);
    scan_result_t res;
    longint qx, qy, qw, qh, xlo, xhi, ylo, yhi, m, ex, ey, ew, eh;
    int span;
    int i;
    res.hit = 1'b0;
    res.hit_index = '0;
    qx = q.box_x;
    qy = q.box_y;
    qw = q.box_width;
    qh = q.box_height;
    m = q.margin;
    xlo = qx;
    xhi = qx + qw;
    ylo = qy;
    yhi = qy + qh;
    case (q.test_kind)
      KIND_LEFT: xhi = qx + 1;
      KIND_RIGHT: xlo = qx + qw - 1;
      KIND_TOP: yhi = qy + 1;
      KIND_BOTTOM: ylo = qy + qh - 1;
      default: ;
    endcase
    span = (q.list_length > SLOTS) ? SLOTS : int'(q.list_length);
    for (i = 0; i < span; i++) begin
      if (tbl_tag[i] == q.box_tag) continue;
      ex = tbl_x[i];
      ey = tbl_y[i];
      ew = tbl_w[i];
      eh = tbl_h[i];
      if (ex + ew + m >= xlo && ex - m <= xhi && ey + eh + m >= ylo && ey - m <= yhi) begin
        res.hit = 1'b1;
        res.hit_index = i[5:0];
        return res;
      end
    end
    return res;
  endfunction

  // Coordinates mostly near the scene center, sometimes anywhere.
  function automatic int pick_coord(int center);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return center + int'($urandom_range(0, 200)) - 100;
  endfunction

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 32767);
    if (r < 20) return $urandom_range(0, 1);
    return $urandom_range(0, 60);
  endfunction

  function automatic box_word_t random_word();
    box_word_t word;
    int r;
    word.mode = ($urandom_range(0, 99) < 35) ? MODE_WRITE : MODE_QUERY;
    word.entry_index = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 3) word.list_length = '0;
    else if (r < 13) word.list_length = 7'($urandom_range(65, 127));
    else if (r < 50) word.list_length = 7'($urandom_range(1, 8));
    else word.list_length = 7'($urandom_range(1, 64));
    r = pick_coord(scene_cx);
    word.box_x = r[15:0];
    r = pick_coord(scene_cy);
    word.box_y = r[15:0];
    word.box_width = 15'(pick_extent());
    word.box_height = 15'(pick_extent());
    word.box_tag = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 3))
                                                : 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 70) r = int'($urandom_range(0, 16)) - 8;
    else if (r < 85) r = 0;
    else r = $urandom_range(0, 8191);
    word.margin = r[12:0];
    word.test_kind = 3'($urandom_range(0, 7));
    return word;
  endfunction

  function automatic int pick_scene();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 32700;
    if (r < 40) return -32700;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Offer one word, idling first at random, and update the shadow table or
  // queue the expected scan result once the word is taken.
  task automatic send_word(input box_word_t word, input bit typed,
                           input scan_result_t typed_result);
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
    end
    in_valid <= 1'b1;
    in_mode <= word.mode;
    in_entry_index <= word.entry_index;
    in_list_length <= word.list_length;
    in_box_x <= word.box_x;
    in_box_y <= word.box_y;
    in_box_width <= word.box_width;
    in_box_height <= word.box_height;
    in_box_tag <= word.box_tag;
    in_margin <= word.margin;
    in_test_kind <= word.test_kind;
    do @(posedge clk); while (!in_ready);
    if (word.mode == MODE_WRITE) store_box(word);
    else scan_expect_q.push_back(typed ? typed_result : scan_table(word));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (scan_expect_q.size() != 0);
  endtask

  // Result side stalls at random, except through the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Compare each result word with the oldest expected scan result.
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (scan_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: hit=%0b index=%0d", out_hit, out_hit_index);
      end else begin
        want = scan_expect_q.pop_front();
        if (out_hit !== want.hit || out_hit_index !== want.hit_index) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("scan result mismatch: expected hit=%0b index=%0d, got hit=%0b index=%0d",
                     want.hit, want.hit_index, out_hit, out_hit_index);
        end
      end
    end
  end

  // End the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("aabb_overlap_scan regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    scan_result_t no_result;
    int n;
    no_result.hit = 1'b0;
    no_result.hit_index = '0;

    // Directed words; typed results are the ones that follow plainly from
    // the parked table.
    add_query(0, 0, 0, 0, 0, 0, 0, KIND_FULL, 1'b1, 1'b0, 0);
    // Every slot carries the query tag, so the long list finds nothing.
    add_query(127, PARK_COORD, PARK_COORD, 0, 0, PARK_TAG, 0, KIND_FULL, 1'b1, 1'b0, 0);
    add_query(127, PARK_COORD, PARK_COORD, 0, 0, 0, 0, KIND_FULL, 1'b1, 1'b1, 0);
    add_write(63, 32767, 32767, 32767, 32767, 16'h1234);
    add_query(64, 32767, 32767, 32767, 32767, PARK_TAG, 0, KIND_FULL, 1'b1, 1'b1, 63);
    add_query(63, 32767, 32767, 32767, 32767, PARK_TAG, 0, KIND_FULL, 1'b1, 1'b0, 0);
    add_write(0, 0, 0, 10, 10, 16'h0001);
    add_query(1, 10, 5, 4, 4, 2, 0, KIND_FULL, 1'b0, 1'b0, 0);
    add_query(1, 10, 5, 4, 4, 2, 0, KIND_LEFT, 1'b0, 1'b0, 0);
    add_query(1, 10, 5, 4, 4, 2, 0, KIND_RIGHT, 1'b0, 1'b0, 0);
    add_query(1, 10, 5, 4, 4, 2, 0, KIND_TOP, 1'b0, 1'b0, 0);
    add_query(1, 10, 5, 4, 4, 2, 0, KIND_BOTTOM, 1'b0, 1'b0, 0);
    add_query(1, 12, 5, 4, 4, 2, 0, KIND_SPARE_LO, 1'b0, 1'b0, 0);
    add_query(1, 10, 5, 4, 4, 2, 0, KIND_SPARE_HI, 1'b0, 1'b0, 0);
    add_query(1, 4000, 4000, 0, 0, 2, 4095, KIND_FULL, 1'b0, 1'b0, 0);
    add_query(1, 5, 5, 0, 0, 2, -4096, KIND_FULL, 1'b0, 1'b0, 0);
    add_query(1, 5, 5, 0, 0, 2, -5, KIND_FULL, 1'b0, 1'b0, 0);
    // A zero-width right strip reaches one column to the left of the query.
    add_query(1, 11, 0, 0, 10, 2, 0, KIND_RIGHT, 1'b0, 1'b0, 0);
    add_write(2, -32768, 32767, 0, 32767, 16'h8000);
    add_query(3, -32768, 32767, 32767, 0, PARK_TAG, 4095, KIND_BOTTOM, 1'b0, 1'b0, 0);
    add_write(0, 0, 0, 10, 10, 16'h7FFF);
    add_query(3, 0, 0, 0, 0, 16'h7FFF, -1, KIND_TOP, 1'b0, 1'b0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Park a box in every slot so that no scan reads an unwritten one.
    for (n = 0; n < SLOTS; n++)
      send_word(make_word(MODE_WRITE, n, 0, PARK_COORD, PARK_COORD, 0, 0, PARK_TAG, 0,
                          KIND_FULL), 1'b0, no_result);

    foreach (script[k])
      send_word(script[k].word, script[k].typed, script[k].result);
    wait_drained();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) begin
        scene_cx = pick_scene();
        scene_cy = pick_scene();
      end
      steady = (n >= 700 && n < 1000);
      if (n == 400 || n == 1400) wait_drained();
      send_word(random_word(), 1'b0, no_result);
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && scan_expect_q.size() == 0) begin
      $display("aabb_overlap_scan regression: pass");
    end else begin
      $display("aabb_overlap_scan regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/aos_pkg.sv
rtl/core/aos_table.sv
rtl/core/aos_test.sv
rtl/core/aabb_overlap_scan.sv
rtl/core/aos_checker.sv
test/aabb_overlap_scan_test.sv
